// ===== sv/mrlf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mrlf_pkg;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_PROMPT = 8'h3e;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // "+IPD" header tag and the place where the count digits start
    localparam int HDR_LEN   = 4;
    localparam int COUNT_POS = 5;
    localparam logic [7:0] HDR_TAG [HDR_LEN] = '{8'h2b, 8'h49, 8'h50, 8'h44};

    localparam logic [15:0] COUNT_MAX = 16'hffff;

    // result kinds
    localparam logic KIND_BINARY = 1'b0;
    localparam logic KIND_LINE   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_READ   = 4'b0100,
        S_PUSH   = 4'b1000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic store;
        logic emit_bin;
        logic hdr_load;
        logic start_emit;
        logic rd_issue;
        logic push;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic zero;
        logic bin_pending;
        logic is_lf;
        logic is_cr;
        logic is_prompt;
        logic len_zero;
        logic hdr_hit;
        logic slot_free;
        logic at_last;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/modem_response_line_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Modem response line framer: takes one received UART byte per request on
// rx_byte and returns binary payload bytes (kind 0, last 1) while a "+IPD"
// count is pending, or whole text lines (kind 1, last on the final byte) when
// CR or '>' ends a line. A byte with no result passes through decode and
// returns to ready; a binary byte is loaded once the output register is free;
// a completed line goes out character by character, each a registered read of
// the line store ahead of an output load that waits for a free output register.
// A result may wait at the output while the block idles for the next byte.
module modem_response_line_framer
    import mrlf_pkg::*;
#(
    parameter int LINE_BYTES = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      data_byte,
    output logic            last
);

    cmd_t    cmd;
    status_t st;

    mrlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    mrlf_dpath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .cmd       (cmd),
        .st        (st),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .kind      (kind),
        .data_byte (data_byte),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== sv/mrlf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrlf_ctrl
    import mrlf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.zero)
                begin
                    state_next = S_IDLE;
                end
                else if (st.bin_pending)
                begin
                    if (st.slot_free)
                    begin
                        cmd.emit_bin = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (st.is_lf)
                begin
                    state_next = S_IDLE;
                end
                else if (st.is_cr)
                begin
                    if (st.len_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.start_emit = 1'b1;
                        state_next     = S_READ;
                    end
                end
                else if (st.is_prompt)
                begin
                    cmd.store      = 1'b1;
                    cmd.start_emit = 1'b1;
                    state_next     = S_READ;
                end
                else
                begin
                    cmd.store    = 1'b1;
                    cmd.hdr_load = st.hdr_hit;
                    state_next   = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_PUSH;
            end
            S_PUSH:
            begin
                if (st.slot_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = st.at_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_last_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && st.slot_free && st.at_last) |=> (state_reg == S_IDLE))
        else $error("line run did not return to idle after its last byte");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_take_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (in_valid && in_ready))
        else $error("request taken without a handshake");
`endif

endmodule

`default_nettype wire

// ===== sv/mrlf_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrlf_dpath
    import mrlf_pkg::*;
#(
    parameter int LINE_BYTES = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] rx_byte,
    input  wire cmd_t       cmd,
    output status_t         st,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic            kind,
    output logic [7:0]      data_byte,
    output logic            last
);

    localparam int IW = $clog2(LINE_BYTES);
    localparam logic [IW-1:0] LEN_MAX = IW'(LINE_BYTES - 1);

    logic [7:0]    mem [LINE_BYTES];
    logic [7:0]    rx_reg;
    logic [7:0]    rd_reg;
    logic [IW-1:0] len_reg;
    logic [IW-1:0] len_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [15:0]   bin_reg;
    logic [15:0]   bin_next;
    logic          prefix_reg;
    logic          prefix_next;
    logic          run_reg;
    logic          run_next;
    logic [15:0]   acc_reg;
    logic [15:0]   acc_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          kind_reg;
    logic          kind_next;
    logic [7:0]    data_reg;
    logic [7:0]    data_next;
    logic          last_reg;
    logic          last_next;

    logic          room;
    logic          store_ok;
    logic          is_digit;
    logic [3:0]    digit;
    logic [19:0]   acc_mul;
    logic [15:0]   acc_sat;
    logic [15:0]   count_val;
    logic          tag_match;
    logic          at_last;
    logic          slot_free;

    // byte classification
    always_comb
    begin
        room      = (len_reg < LEN_MAX);
        store_ok  = cmd.store && room;
        is_digit  = (rx_reg inside {[CH_ZERO:CH_NINE]});
        digit     = rx_reg[3:0];
        tag_match = (rx_reg == HDR_TAG[len_reg[1:0]]);
        at_last   = (idx_reg == len_reg - IW'(1));
        slot_free = !out_valid_reg || out_ready;
        count_val = (len_reg == IW'(COUNT_POS)) ? 16'd0 : acc_reg;
    end

    // decimal accumulate, acc*10 + digit, saturating
    always_comb
    begin
        acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {16'd0, digit};
        acc_sat = (acc_mul > {4'd0, COUNT_MAX}) ? COUNT_MAX : acc_mul[15:0];
    end

    // status to controller
    always_comb
    begin
        st.zero        = (rx_reg == CH_NUL);
        st.bin_pending = (bin_reg != 16'd0);
        st.is_lf       = (rx_reg == CH_LF);
        st.is_cr       = (rx_reg == CH_CR);
        st.is_prompt   = (rx_reg == CH_PROMPT);
        st.len_zero    = (len_reg == '0);
        st.hdr_hit     = room && prefix_reg && (rx_reg == CH_COLON)
                         && (len_reg >= IW'(COUNT_POS));
        st.slot_free   = slot_free;
        st.at_last     = at_last;
    end

    // line length, read index, header tracking
    always_comb
    begin
        len_next    = len_reg;
        idx_next    = idx_reg;
        prefix_next = prefix_reg;
        run_next    = run_reg;
        acc_next    = acc_reg;
        bin_next    = bin_reg;

        if (cmd.hdr_load || (cmd.push && at_last))
        begin
            len_next = '0;
        end
        else if (store_ok)
        begin
            len_next = len_reg + IW'(1);
        end

        if (cmd.start_emit)
        begin
            idx_next = '0;
        end
        else if (cmd.push && !at_last)
        begin
            idx_next = idx_reg + IW'(1);
        end

        if (store_ok)
        begin
            if (len_reg == '0)
            begin
                prefix_next = tag_match;
            end
            else if (len_reg < IW'(HDR_LEN))
            begin
                prefix_next = prefix_reg && tag_match;
            end

            if (len_reg == IW'(COUNT_POS))
            begin
                run_next = is_digit;
                acc_next = is_digit ? {12'd0, digit} : 16'd0;
            end
            else if (len_reg > IW'(COUNT_POS))
            begin
                if (run_reg && is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    run_next = 1'b0;
                end
            end
        end

        if (cmd.hdr_load)
        begin
            bin_next = count_val;
        end
        else if (cmd.emit_bin)
        begin
            bin_next = bin_reg - 16'd1;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        if (cmd.emit_bin)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_BINARY;
            data_next      = rx_reg;
            last_next      = 1'b1;
        end
        else if (cmd.push)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_LINE;
            data_next      = rd_reg;
            last_next      = at_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            idx_reg       <= '0;
            bin_reg       <= 16'd0;
            prefix_reg    <= 1'b0;
            run_reg       <= 1'b0;
            acc_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            bin_reg       <= bin_next;
            prefix_reg    <= prefix_next;
            run_reg       <= run_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rx_reg <= rx_byte;
        end
        kind_reg <= kind_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    // line store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (store_ok)
        begin
            mem[len_reg] <= rx_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data_byte = data_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("line length beyond store capacity");

    a_bin_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_bin |-> (bin_reg != 16'd0))
        else $error("binary byte sent with no count pending");

    a_bin_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_bin && !cmd.hdr_load) |=> (bin_reg == $past(bin_reg) - 16'd1))
        else $error("binary count did not drop by one");

    a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.emit_bin) |-> slot_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

// ===== tb/modem_response_line_framer_test.sv =====
`timescale 1ns / 1ps

module modem_response_line_framer_test;
    import mrlf_pkg::*;

    localparam int LINE_BYTES   = 64;
    localparam int LINE_MAX     = LINE_BYTES - 1;
    localparam int RANDOM_BYTES = 250;
    localparam int HOLD_AFTER   = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * LINE_BYTES + 40;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_flag;
    } frame_byte_t;

    typedef enum int {
        READY_ALL,
        READY_HALF,
        READY_QUARTER,
        READY_RARE
    } ready_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       kind;
    logic [7:0] data_byte;
    logic       last;

    // mirror of the framer state
    logic [15:0] bin_left = '0;
    logic [7:0]  line_buf [LINE_BYTES];
    int          line_len = 0;

    frame_byte_t results_due [$];
    logic [7:0]  rx_stream [$];

    int   failures = 0;
    int   requests_taken = 0;
    int   cycle_count = 0;
    logic req_taken = 1'b0;

    int          burst_left = 0;
    int          gap_left = 0;
    ready_mode_t ready_mode = READY_ALL;
    int          mode_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    modem_response_line_framer #(
        .LINE_BYTES (LINE_BYTES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .last      (last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // send the held line out byte by byte and clear it
    task automatic emit_line_bytes();
        for (int i = 0; i < line_len; i++)
            results_due.push_back(frame_byte_t'{KIND_LINE, line_buf[i], i == line_len - 1});
        line_len = 0;
    endtask

    // a full store drops the byte
    function automatic bit append_char(logic [7:0] b);
        if (line_len >= LINE_MAX)
            return 1'b0;
        line_buf[line_len] = b;
        line_len++;
        return 1'b1;
    endfunction

    // expected results of one accepted byte
    task automatic frame_rx_byte(logic [7:0] b);
        bit hdr;
        int count;
        if (b == CH_NUL)
            return;
        if (bin_left != 0)
        begin
            bin_left = bin_left - 16'd1;
            results_due.push_back(frame_byte_t'{KIND_BINARY, b, 1'b1});
        end
        else if (b == CH_CR)
        begin
            if (line_len != 0)
                emit_line_bytes();
        end
        else if (b == CH_PROMPT)
        begin
            void'(append_char(b));
            emit_line_bytes();
        end
        else if (b != CH_LF && append_char(b))
        begin
            // header line: tag, more than five bytes, ends in a colon
            hdr = line_len > COUNT_POS && line_buf[line_len - 1] == CH_COLON;
            if (hdr)
                for (int i = 0; i < HDR_LEN; i++)
                    if (line_buf[i] != HDR_TAG[i])
                        hdr = 1'b0;
            if (hdr)
            begin
                count = 0;
                for (int i = COUNT_POS; i < line_len; i++)
                begin
                    if (line_buf[i] < CH_ZERO || line_buf[i] > CH_NINE)
                        break;
                    count = count * 10 + (line_buf[i] - CH_ZERO);
                    if (count > COUNT_MAX)
                        count = COUNT_MAX;
                end
                bin_left = count[15:0];
                line_len = 0;
            end
        end
    endtask

    // request capture and result check
    always @(posedge clk)
    begin
        frame_byte_t want;
        req_taken <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            requests_taken <= requests_taken + 1;
            frame_rx_byte(rx_byte);
        end
        if (out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: kind %0d data_byte 0x%02h last %0d",
                       kind, data_byte, last);
                failures++;
            end
            else
            begin
                want = results_due.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    failures++;
                end
                if (data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, data_byte);
                    failures++;
                end
                if (last !== want.last_flag)
                begin
                    $error("last: expected %0d, got %0d", want.last_flag, last);
                    failures++;
                end
            end
        end
    end

    // sender: bursts of requests with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (rx_stream.size() != 0)
            begin
                in_valid <= 1'b1;
                rx_byte <= rx_stream.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: changing stall patterns, one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && requests_taken >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= ready_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 200);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                READY_ALL:     out_ready <= 1'b1;
                READY_HALF:    out_ready <= 1'($urandom_range(0, 1));
                READY_QUARTER: out_ready <= (cycle_count % 4 == 0);
                default:       out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            rx_stream.push_back(s[i]);
    endtask

    // any line character that does not end the line
    function automatic logic [7:0] line_char();
        logic [7:0] c;
        do
        begin
            c = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                               : $urandom_range(8'h20, 8'h7e));
        end
        while (c == CH_CR || c == CH_LF || c == CH_PROMPT);
        return c;
    endfunction

    // n payload bytes; zero bytes ride along without counting
    task automatic push_binary(int n);
        logic [7:0] b;
        while (n > 0)
        begin
            b = 8'($urandom_range(0, 255));
            rx_stream.push_back(b);
            if (b != CH_NUL)
                n--;
        end
    endtask

    task automatic push_line(int len);
        for (int i = 0; i < len; i++)
            rx_stream.push_back(line_char());
    endtask

    initial
    begin
        int    start;
        int    n;
        int    k;
        string s;

        // directed: zero byte, plain line, empty line, bare prompt
        rx_stream.push_back(CH_NUL);
        push_text("OK");
        rx_stream.push_back(CH_CR);
        rx_stream.push_back(CH_LF);
        rx_stream.push_back(CH_CR);
        rx_stream.push_back(CH_PROMPT);
        // header with three payload bytes, a zero among them
        push_text("+IPD,3");
        rx_stream.push_back(CH_COLON);
        rx_stream.push_back(CH_NUL);
        rx_stream.push_back(8'hff);
        rx_stream.push_back(CH_CR);
        rx_stream.push_back(CH_LF);
        // header with no digits gives a zero count
        push_text("+IPD,");
        rx_stream.push_back(CH_COLON);
        rx_stream.push_back(8'h01);
        rx_stream.push_back(8'h80);
        rx_stream.push_back(CH_PROMPT);

        // overflowing line closed by a prompt that no longer fits
        start = rx_stream.size();
        push_line(LINE_MAX + 5);
        rx_stream.push_back(CH_PROMPT);

        // random traffic, mostly well-formed modem responses
        while (rx_stream.size() - start < RANDOM_BYTES)
        begin
            k = $urandom_range(0, 99);
            if (k < 35)
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(LINE_MAX - 3, LINE_MAX + 6)
                                                 : $urandom_range(0, 12);
                push_line(n);
                if ($urandom_range(0, 3) == 0)
                    rx_stream.push_back(CH_PROMPT);
                else
                begin
                    rx_stream.push_back(CH_CR);
                    rx_stream.push_back(CH_LF);
                end
            end
            else if (k < 60)
            begin
                rx_stream.push_back(CH_CR);
                rx_stream.push_back(CH_LF);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
                if ($urandom_range(0, 3) == 0)
                begin
                    // link id first: the count stops at the comma
                    k = $urandom_range(0, 4);
                    push_text($sformatf("+IPD,%0d,%0d", k, n));
                    n = k;
                end
                else
                    push_text($sformatf("+IPD,%0d", n));
                rx_stream.push_back(CH_COLON);
                push_binary(n);
            end
            else if (k < 75)
            begin
                rx_stream.push_back(CH_CR);
                rx_stream.push_back(CH_LF);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        // corrupted tag
                        s = "+IPD,4";
                        s[$urandom_range(0, 3)] = "?";
                        push_text(s);
                        rx_stream.push_back(CH_COLON);
                    end
                    1:
                    begin
                        // too short to be a header
                        push_text("+IPD");
                        rx_stream.push_back(CH_COLON);
                    end
                    default:
                        push_text("+IPD,12");
                endcase
                rx_stream.push_back(CH_CR);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    rx_stream.push_back(8'($urandom_range(0, 255)));
            end
        end

        // saturating count, left pending at the end
        rx_stream.push_back(CH_CR);
        rx_stream.push_back(CH_LF);
        push_text("+IPD,99999");
        rx_stream.push_back(CH_COLON);
        push_binary(6);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (rx_stream.size() != 0 || in_valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
